>>> design/rpcf_pkg.sv
// Shared codes for the chunked byte ring FIFO.
package rpcf_pkg;

  typedef enum logic [1:0] {
    FUNC_WR_REQ  = 2'd0,
    FUNC_WR_DATA = 2'd1,
    FUNC_RD_REQ  = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_WOULD_BLOCK = 2'd1,
    ST_NO_WRITE    = 2'd2,
    ST_WRITE_OWED  = 2'd3
  } status_e;

  localparam int unsigned CntW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LvlW  = 6;
  localparam int unsigned ExtW  = 7;

endpackage

>>> design/ring_pipe_chunk_fifo.sv
// Byte ring FIFO that grants only contiguous chunks and keeps one slot empty.
//
//  channel   | dir | tdata (low bit first)                     | tuser  | tlast
//  s_axis    | in  | request_count[15:0], write_byte[7:0]      | func   | -
//  m_axis    | out | granted[5:0], read_byte[7:0], fill_level  | status | last
//
// Every request except a granted read or the unused code yields one result, registered
// in the cycle after acceptance; the unused code yields none. A granted read of g bytes
// yields g results: the ring memory has one read port with a registered output, so one
// byte leaves per cycle after the first read while m_axis does not stall.
// Reset clears the pointers, fill and owed count; the ring memory is not cleared.
// A stalled m_axis holds the result register and the read stream; s_axis waits until
// the pending read stream has fully moved into the result register.
module ring_pipe_chunk_fifo #(
  parameter int unsigned RingDepth = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // request_count [15:0], write_byte [23:16]
  input  logic [23:0]                 s_axis_tdata_i,
  // func [1:0]
  input  rpcf_pkg::func_e             s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // granted [5:0], read_byte [13:6], fill_level [19:14], zero [23:20]
  output logic [23:0]                 m_axis_tdata_o,
  // status [1:0]
  output rpcf_pkg::status_e           m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);
  import rpcf_pkg::*;

  localparam int unsigned PW = $clog2(RingDepth);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e             state_q, state_d;
  logic [PW-1:0]      rp_q, rp_d, wp_q, wp_d;
  logic [LvlW-1:0]    fill_q, fill_d, owed_q, owed_d;
  logic [LvlW-1:0]    rem_q, rem_d, gr_q, gr_d;
  logic               pend_q, pend_d, pend_last_q, pend_last_d;
  logic [LvlW-1:0]    pend_fill_q, pend_fill_d;

  logic               out_v_q, out_v_d, out_last_q, out_last_d;
  status_e            out_st_q, out_st_d;
  logic [LvlW-1:0]    out_gr_q, out_gr_d, out_fill_q, out_fill_d;
  logic [ByteW-1:0]   out_byte_q, out_byte_d;

  logic [ByteW-1:0]   ring_mem [RingDepth];
  logic [ByteW-1:0]   mem_rd_q;
  logic               rd_en, wr_en;

  logic               in_acc, out_free, load_now;
  logic [CntW-1:0]    req_cnt;
  logic [ByteW-1:0]   wr_byte;
  logic [ExtW-1:0]    wp_inc, rp_inc, room, avail, held;
  logic [PW-1:0]      wp_nxt, rp_nxt;
  logic [LvlW-1:0]    wr_grant, rd_grant;

  assign req_cnt = s_axis_tdata_i[15:0];
  assign wr_byte = s_axis_tdata_i[23:16];

  assign out_free        = !out_v_q || m_axis_tready_i;
  assign load_now        = pend_q && out_free;
  assign s_axis_tready_o = (state_q == S_IDLE) && !pend_q && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Pointer advance with wrap at the buffer end
  assign wp_inc = ExtW'(wp_q) + ExtW'(1);
  assign rp_inc = ExtW'(rp_q) + ExtW'(1);
  assign wp_nxt = (wp_inc >= ExtW'(RingDepth)) ? '0 : wp_inc[PW-1:0];
  assign rp_nxt = (rp_inc >= ExtW'(RingDepth)) ? '0 : rp_inc[PW-1:0];

  // Contiguous free space and contiguous held bytes
  always_comb begin
    if (wp_q >= rp_q) begin
      room = ExtW'(RingDepth) - ExtW'(wp_q) - ((rp_q == '0) ? ExtW'(1) : ExtW'(0));
    end else begin
      room = ExtW'(rp_q) - ExtW'(1) - ExtW'(wp_q);
    end
    if (wp_q > rp_q) begin
      avail = ExtW'(wp_q) - ExtW'(rp_q);
    end else begin
      avail = ExtW'(RingDepth) - ExtW'(rp_q);
    end
  end

  assign wr_grant = (req_cnt < CntW'(room))  ? req_cnt[LvlW-1:0] : room[LvlW-1:0];
  assign rd_grant = (req_cnt < CntW'(avail)) ? req_cnt[LvlW-1:0] : avail[LvlW-1:0];

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    owed_d      = owed_q;
    rem_d       = rem_q;
    gr_d        = gr_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    pend_fill_d = pend_fill_q;
    out_v_d     = out_v_q && !m_axis_tready_i;
    out_st_d    = out_st_q;
    out_gr_d    = out_gr_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_fill_d  = out_fill_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;

    // Move a fetched ring byte into the result register
    if (load_now) begin
      pend_d     = 1'b0;
      out_v_d    = 1'b1;
      out_st_d   = ST_OK;
      out_gr_d   = gr_q;
      out_byte_d = mem_rd_q;
      out_last_d = pend_last_q;
      out_fill_d = pend_fill_q;
    end

    if (in_acc) begin
      out_st_d   = ST_OK;
      out_gr_d   = '0;
      out_byte_d = '0;
      out_last_d = 1'b1;
      out_fill_d = fill_q;
      case (s_axis_tuser_i)
        FUNC_WR_REQ: begin
          out_v_d = 1'b1;
          if (owed_q != '0) begin
            out_st_d = ST_WRITE_OWED;
          end else if (wp_nxt == rp_q) begin
            out_st_d = ST_WOULD_BLOCK;
          end else begin
            out_gr_d = wr_grant;
            owed_d   = wr_grant;
          end
        end
        FUNC_WR_DATA: begin
          out_v_d = 1'b1;
          if (owed_q == '0) begin
            out_st_d = ST_NO_WRITE;
          end else begin
            wr_en      = 1'b1;
            wp_d       = wp_nxt;
            fill_d     = fill_q + LvlW'(1);
            owed_d     = owed_q - LvlW'(1);
            out_fill_d = fill_q + LvlW'(1);
          end
        end
        FUNC_RD_REQ: begin
          if (rp_q == wp_q) begin
            out_v_d  = 1'b1;
            out_st_d = ST_WOULD_BLOCK;
          end else if (rd_grant == '0) begin
            out_v_d = 1'b1;
          end else begin
            state_d = S_READ;
            rem_d   = rd_grant;
            gr_d    = rd_grant;
          end
        end
        default: begin
        end
      endcase
    end

    // Fetch the next byte when the fetched one has gone or will go this cycle
    if ((state_q == S_READ) && (!pend_q || out_free)) begin
      rd_en       = 1'b1;
      rp_d        = rp_nxt;
      fill_d      = fill_q - LvlW'(1);
      rem_d       = rem_q - LvlW'(1);
      pend_d      = 1'b1;
      pend_fill_d = fill_q - LvlW'(1);
      pend_last_d = (rem_q == LvlW'(1));
      if (rem_q == LvlW'(1)) begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      owed_q      <= '0;
      rem_q       <= '0;
      gr_q        <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      pend_fill_q <= '0;
      out_v_q     <= 1'b0;
      out_st_q    <= ST_OK;
      out_gr_q    <= '0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      out_fill_q  <= '0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      owed_q      <= owed_d;
      rem_q       <= rem_d;
      gr_q        <= gr_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      pend_fill_q <= pend_fill_d;
      out_v_q     <= out_v_d;
      out_st_q    <= out_st_d;
      out_gr_q    <= out_gr_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
      out_fill_q  <= out_fill_d;
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wp_q] <= wr_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mem_rd_q <= ring_mem[rp_q];
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {4'd0, out_fill_q, out_byte_q, out_gr_q};

  assign held = (wp_q >= rp_q) ? (ExtW'(wp_q) - ExtW'(rp_q))
                               : (ExtW'(wp_q) + ExtW'(RingDepth) - ExtW'(rp_q));

  a_fill_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ExtW'(fill_q) == held)
    else $error("fill level out of step with pointers");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ExtW'(fill_q) < ExtW'(RingDepth))
    else $error("ring overfilled");

  a_read_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (rem_q != '0) && (rem_q <= gr_q))
    else $error("read stream count out of range");

  a_no_accept_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !pend_q && (!out_v_q || m_axis_tready_i))
    else $error("request accepted over a held result");

  a_last_ends_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && pend_last_q) |-> (state_q == S_IDLE))
    else $error("final byte fetched with stream still open");

endmodule
